/* rtl/core/tpkt_stream_deframer_core_defines.svh */
// Assertion macros for the TPKT stream deframer core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TPKT_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define TPKT_STREAM_DEFRAMER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define TSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define TSD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/tpkt_sd_pkg.sv */
// Package for the TPKT stream deframer core: types, codes and constants.
// No dependencies.
`default_nettype none

package tpkt_sd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TPKT_ENABLED = 2'd0;
    localparam logic [1:0] CFG_ASCII_MODE   = 2'd1;
    localparam logic [1:0] CFG_MIN_PAYLOAD  = 2'd2;

    // Byte tags
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CONT    = 2'd2;

    // Header constants
    localparam logic [7:0]  TPKT_VERSION   = 8'd3;
    localparam logic [7:0]  ASCII_ZERO     = 8'd48;
    localparam logic [7:0]  ASCII_LOWER_OF = 8'd87;
    localparam logic [7:0]  ASCII_UPPER_OF = 8'd55;
    localparam logic [7:0]  DEC_MAX        = 8'd9;
    localparam logic [16:0] BIN_HDR_LEN    = 17'd4;
    localparam logic [3:0]  BIN_LAST_IDX   = 4'd3;
    localparam logic [3:0]  ASC_LAST_IDX   = 4'd8;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CONT    = 2'd2
    } phase_t;

    typedef struct packed {
        logic        tpkt_enabled;
        logic        ascii_mode;
        logic [15:0] min_payload;
    } tsd_cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_kind;
        logic        header_done;
        logic [7:0]  hdr_version;
        logic [7:0]  hdr_reserved;
        logic [15:0] hdr_length;
        logic        pdu_last;
    } tsd_result_t;

endpackage

`default_nettype wire

/* rtl/core/tpkt_sd_if.sv */
// Valid/ready channel interfaces for the TPKT stream deframer core.
// No dependencies.
`default_nettype none

interface tpkt_sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface tpkt_sd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic        header_done;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_reserved;
    logic [15:0] hdr_length;
    logic        pdu_last;

    modport source (output valid, output out_byte, output byte_kind, output header_done,
                    output hdr_version, output hdr_reserved, output hdr_length,
                    output pdu_last, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input header_done,
                    input hdr_version, input hdr_reserved, input hdr_length,
                    input pdu_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/tpkt_sd_engine.sv */
// Framing state and per-byte decode for the TPKT stream deframer.
// Depends on tpkt_sd_pkg.
`default_nettype none

module tpkt_sd_engine
    import tpkt_sd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [7:0]  data_byte,
    input  wire logic        stream_start,
    input  wire tsd_cfg_t    cfg,
    output tsd_result_t      result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  rsv_reg, rsv_next;
    logic [3:0]  digit_reg, digit_next;
    logic [15:0] left_reg, left_next;

    // Update framing state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            idx_reg   <= '0;
            len_reg   <= '0;
            ver_reg   <= '0;
            rsv_reg   <= '0;
            digit_reg <= '0;
            left_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            ver_reg   <= ver_next;
            rsv_reg   <= rsv_next;
            digit_reg <= digit_next;
            left_reg  <= left_next;
        end
    end

    // Decode one byte against the current framing state
    always_comb
    begin
        phase_t      ph;
        logic [3:0]  idx;
        logic [16:0] len_min;
        logic [7:0]  dsub;
        logic [1:0]  kind;
        logic        show;
        logic        done;
        logic        last;

        ph         = phase_reg;
        idx        = idx_reg;
        len_next   = len_reg;
        ver_next   = ver_reg;
        rsv_next   = rsv_reg;
        digit_next = digit_reg;
        left_next  = left_reg;
        kind       = KIND_CONT;
        show       = 1'b0;
        done       = 1'b0;
        last       = 1'b0;
        len_min    = BIN_HDR_LEN + {1'b0, cfg.min_payload};
        dsub       = '0;

        // Restart framing at a new stream
        if (stream_start)
        begin
            ph         = PH_HEADER;
            idx        = '0;
            len_next   = '0;
            ver_next   = '0;
            rsv_next   = '0;
            digit_next = '0;
            left_next  = '0;
        end
        phase_next = ph;
        idx_next   = idx;

        if (cfg.tpkt_enabled && ph == PH_HEADER)
        begin
            if (idx == '0)
            begin
                ver_next   = '0;
                rsv_next   = '0;
                len_next   = '0;
                digit_next = '0;
            end
            if (!cfg.ascii_mode)
            begin
                if (idx == 4'd0)
                begin
                    if (data_byte != TPKT_VERSION)
                    begin
                        phase_next = PH_CONT;
                    end
                    else
                    begin
                        ver_next = data_byte;
                        kind = KIND_HEADER; show = 1'b1; idx_next = 4'd1;
                    end
                end
                else if (idx == 4'd1)
                begin
                    rsv_next = data_byte;
                    kind = KIND_HEADER; show = 1'b1; idx_next = 4'd2;
                end
                else if (idx == 4'd2)
                begin
                    len_next = {8'd0, data_byte};
                    kind = KIND_HEADER; show = 1'b1; idx_next = BIN_LAST_IDX;
                end
                else
                begin
                    len_next = {len_next[7:0], data_byte};
                    idx_next = '0;
                    if ({1'b0, len_next} < len_min)
                    begin
                        phase_next = PH_CONT;
                    end
                    else
                    begin
                        kind = KIND_HEADER; show = 1'b1; done = 1'b1;
                        left_next = len_next - BIN_HDR_LEN[15:0];
                        if (left_next == '0)
                            last = 1'b1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
            end
            else
            begin
                if (idx == 4'd0 && data_byte != ASCII_ZERO)
                begin
                    phase_next = PH_CONT;
                end
                else if (idx >= ASC_LAST_IDX)
                begin
                    kind = KIND_HEADER; show = 1'b1; done = 1'b1;
                    idx_next  = '0;
                    left_next = len_next;
                    if (left_next == '0)
                        last = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
                else
                begin
                    // Each field starts its digit history from zero
                    if (idx == 4'd2 || idx == 4'd4)
                        digit_next = '0;
                    // Keep the previous digit on a non-hex character
                    if (data_byte >= ASCII_ZERO && data_byte <= ASCII_ZERO + DEC_MAX)
                        dsub = data_byte - ASCII_ZERO;
                    else if (data_byte >= 8'h61 && data_byte <= 8'h66)
                        dsub = data_byte - ASCII_LOWER_OF;
                    else if (data_byte >= 8'h41 && data_byte <= 8'h46)
                        dsub = data_byte - ASCII_UPPER_OF;
                    else
                        dsub = {4'd0, digit_next};
                    digit_next = dsub[3:0];
                    if (idx < 4'd2)
                        ver_next = {ver_next[3:0], digit_next};
                    else if (idx < 4'd4)
                        rsv_next = {rsv_next[3:0], digit_next};
                    else
                        len_next = {len_next[11:0], digit_next};
                    kind = KIND_HEADER; show = 1'b1;
                    idx_next = idx + 4'd1;
                end
            end
        end
        else if (cfg.tpkt_enabled && ph == PH_PAYLOAD)
        begin
            kind = KIND_PAYLOAD; show = 1'b1;
            if (left_next <= 16'd1)
            begin
                left_next  = '0;
                last       = 1'b1;
                phase_next = PH_HEADER;
                idx_next   = '0;
            end
            else
            begin
                left_next = left_next - 16'd1;
            end
        end

        result.out_byte     = data_byte;
        result.byte_kind    = kind;
        result.header_done  = done;
        result.hdr_version  = show ? ver_next : 8'd0;
        result.hdr_reserved = show ? rsv_next : 8'd0;
        result.hdr_length   = show ? len_next : 16'd0;
        result.pdu_last     = last;
    end

endmodule

`default_nettype wire

/* rtl/core/tpkt_stream_deframer_core.sv */
// A byte accepted into the input register reaches the output when the result register takes it.
// Throughput: one byte per cycle while the output is not stalled; the framing state is updated
// once per byte, as a byte moves from the input register into the result register.
// Reset (rst_n, async low): config to enabled / binary / min payload 0,
// framing to header phase with all counters zero, both stages emptied.
// Top level of the TPKT stream deframer; depends on tpkt_sd_pkg, tpkt_sd_if,
// tpkt_sd_engine and tpkt_stream_deframer_core_defines.svh.
`default_nettype none
`include "tpkt_stream_deframer_core_defines.svh"

module tpkt_stream_deframer_core
    import tpkt_sd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tpkt_sd_in_if.sink       in_ch,
    tpkt_sd_out_if.source    out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    tsd_cfg_t    cfg_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;
    logic        out_valid_reg;
    tsd_result_t out_reg;
    tsd_result_t result;
    logic        out_free;
    logic        advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tpkt_enabled <= 1'b1;
            cfg_reg.ascii_mode   <= 1'b0;
            cfg_reg.min_payload  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TPKT_ENABLED: cfg_reg.tpkt_enabled <= cfg_wdata[0];
                CFG_ASCII_MODE:   cfg_reg.ascii_mode   <= cfg_wdata[0];
                CFG_MIN_PAYLOAD:  cfg_reg.min_payload  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Advance when the result register is empty or being drained
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg  <= in_ch.data_byte;
            s1_start_reg <= in_ch.stream_start;
        end
    end

    tpkt_sd_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .data_byte    (s1_byte_reg),
        .stream_start (s1_start_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_byte     = out_reg.out_byte;
    assign out_ch.byte_kind    = out_reg.byte_kind;
    assign out_ch.header_done  = out_reg.header_done;
    assign out_ch.hdr_version  = out_reg.hdr_version;
    assign out_ch.hdr_reserved = out_reg.hdr_reserved;
    assign out_ch.hdr_length   = out_reg.hdr_length;
    assign out_ch.pdu_last     = out_reg.pdu_last;

    // A completed header is always tagged as header
    `TSD_ASSERT(a_done_is_header, out_ch.valid && out_ch.header_done |-> out_ch.byte_kind == KIND_HEADER, "header_done on a non-header transaction")

    // Continuation bytes carry no framing information
    `TSD_ASSERT_NEVER(a_cont_clean, out_ch.valid && out_ch.byte_kind == KIND_CONT && (out_ch.pdu_last || out_ch.header_done || out_ch.hdr_length != 16'd0), "continuation transaction with framing fields")

    // A held input stage is not lost while the output is stalled
    `TSD_ASSERT(a_s1_hold, s1_valid_reg && !out_free |=> s1_valid_reg, "input stage dropped a transaction under stall")

endmodule

`default_nettype wire
